// ===== rtl/core/slz_pkg.sv =====
// Package for the SHA-256 leading-zero nonce search block.
// Holds request/result structs, controller states, SHA-256 constants and helpers.
// No dependencies.
package slz_pkg;

  localparam int WordW = 64;
  localparam int DiffW = 9;
  localparam int CfgIdxW = 1;
  localparam int HashBits = 256;
  localparam logic [DiffW-1:0] DiffReset = 9'd16;
  localparam logic [WordW-1:0] MaxAttReset = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [CfgIdxW-1:0] RegDifficulty = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMaxAttempts = 1'b1;

  typedef struct packed {
    logic [63:0] target_w0;
    logic [63:0] target_w1;
    logic [63:0] target_w2;
    logic [63:0] target_w3;
    logic [63:0] start_nonce;
    logic [63:0] filler_w0;
    logic [63:0] filler_w1;
    logic [63:0] filler_w2;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [63:0] nonce_value;
    logic [63:0] hashes_tried;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD1, ST_RUN1, ST_LOAD2, ST_RUN2, ST_CHECK, ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_job;    // capture request
    logic next_nonce;  // bump nonce and attempt count
    logic load_blk1;   // init hash, load data block
    logic load_blk2;   // load padding block
    logic round;       // run one round
    logic finish;      // add working vars to hash
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_round;
    logic qualifies;
    logic at_limit;
  } dp_sts_t;

  localparam logic [31:0] KRound [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [255:0] HInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] x);
    swap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// ===== rtl/core/sha256_leading_zero_nonce_search_top.sv =====
// SHA-256 leading-zero nonce search, top level.
// Each attempt loads the data block, runs a 64-round compression one round per
// cycle, loads the padding block, runs a second 64-round compression and checks
// the digest. One job at a time: a new request is taken only after the result is taken.
// rst (synchronous, active high) clears the controller, difficulty to 16 and
// max_attempts to all ones. Depends on slz_pkg, slz_ctrl, slz_datapath.
module sha256_leading_zero_nonce_search_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  slz_pkg::req_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output slz_pkg::rsp_t                  out_data,
  input  logic                           cfg_we,
  input  logic [slz_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [slz_pkg::WordW-1:0]      cfg_wdata
);

  logic [slz_pkg::DiffW-1:0] difficulty;
  logic [slz_pkg::WordW-1:0] max_attempts;
  slz_pkg::dp_cmd_t cmd;
  slz_pkg::dp_sts_t sts;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      difficulty <= slz_pkg::DiffReset;
      max_attempts <= slz_pkg::MaxAttReset;
    end else if (cfg_we) begin
      case (cfg_index)
        slz_pkg::RegDifficulty:  difficulty <= cfg_wdata[slz_pkg::DiffW-1:0];
        slz_pkg::RegMaxAttempts: max_attempts <= cfg_wdata;
        default: ;
      endcase
    end
  end

  slz_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  slz_datapath u_dp (
    .clk, .rst, .req(in_data), .difficulty, .max_attempts, .cmd, .sts, .rsp(out_data)
  );

endmodule

// ===== rtl/core/slz_ctrl.sv =====
// Controller state machine for the nonce search.
// Depends on slz_pkg; drives slz_datapath through dp_cmd_t.
module slz_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output slz_pkg::dp_cmd_t    cmd,
  input  slz_pkg::dp_sts_t    sts
);

  slz_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= slz_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      slz_pkg::ST_IDLE:  if (in_valid) state_next = slz_pkg::ST_LOAD1;
      slz_pkg::ST_LOAD1: state_next = slz_pkg::ST_RUN1;
      slz_pkg::ST_RUN1:  if (sts.last_round) state_next = slz_pkg::ST_LOAD2;
      slz_pkg::ST_LOAD2: state_next = slz_pkg::ST_RUN2;
      slz_pkg::ST_RUN2:  if (sts.last_round) state_next = slz_pkg::ST_CHECK;
      slz_pkg::ST_CHECK: begin
        if (sts.qualifies || sts.at_limit) state_next = slz_pkg::ST_DONE;
        else                               state_next = slz_pkg::ST_LOAD1;
      end
      slz_pkg::ST_DONE:  if (out_ready) state_next = slz_pkg::ST_IDLE;
      default:           state_next = slz_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      slz_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take_job = in_valid;
      end
      slz_pkg::ST_LOAD1: begin
        cmd.load_blk1 = 1'b1;
        cmd.next_nonce = 1'b1;
      end
      slz_pkg::ST_RUN1:  begin
        cmd.round = 1'b1;
        cmd.finish = sts.last_round;
      end
      slz_pkg::ST_LOAD2: cmd.load_blk2 = 1'b1;
      slz_pkg::ST_RUN2:  begin
        cmd.round = 1'b1;
        cmd.finish = sts.last_round;
      end
      slz_pkg::ST_DONE:  out_valid = 1'b1;
      default: ;
    endcase
  end

  // A result is offered only after a check state
  a_done_from_check: assert property (@(posedge clk) disable iff (rst)
    (state == slz_pkg::ST_DONE && $past(state) != slz_pkg::ST_DONE) |->
      $past(state) == slz_pkg::ST_CHECK)
    else $error("done entered without check");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request and result overlap");
  a_round_only_running: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> cmd.round)
    else $error("finish outside a compression");

endmodule

// ===== rtl/core/slz_datapath.sv =====
// Datapath: job registers, one-round-per-cycle SHA-256 core, zero count test.
// Depends on slz_pkg; commanded by slz_ctrl.
module slz_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  slz_pkg::req_t                req,
  input  logic [slz_pkg::DiffW-1:0]    difficulty,
  input  logic [slz_pkg::WordW-1:0]    max_attempts,
  input  slz_pkg::dp_cmd_t             cmd,
  output slz_pkg::dp_sts_t             sts,
  output slz_pkg::rsp_t                rsp
);

  slz_pkg::req_t job;
  logic [63:0]  nonce;
  logic [63:0]  attempts;
  logic [31:0]  hv [8];
  logic [31:0]  v [8];
  logic [31:0]  w [16];
  logic [5:0]   rnd;

  logic [31:0] wt, s0, s1, t1, t2, ch, maj, e, a;
  logic [63:0] nonce_inc;
  logic [8:0]  zeros;
  logic [8:0]  need;
  logic [63:0] limit;
  logic        nz_found;

  assign nonce_inc = nonce + 64'd1;

  // Schedule word for this round
  always_comb begin
    s0 = slz_pkg::rotr(w[1], 7) ^ slz_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = slz_pkg::rotr(w[14], 17) ^ slz_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    if (rnd < 6'd16) wt = w[0];
    else             wt = w[0] + s0 + w[9] + s1;
  end

  // Round function
  always_comb begin
    e = v[4];
    a = v[0];
    ch = (e & v[5]) ^ (~e & v[6]);
    maj = (a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]);
    t1 = v[7] + (slz_pkg::rotr(e, 6) ^ slz_pkg::rotr(e, 11) ^ slz_pkg::rotr(e, 25))
         + ch + slz_pkg::KRound[rnd] + wt;
    t2 = (slz_pkg::rotr(a, 2) ^ slz_pkg::rotr(a, 13) ^ slz_pkg::rotr(a, 22)) + maj;
  end

  // Job, nonce and attempt registers
  always_ff @(posedge clk) begin
    if (cmd.take_job) begin
      job <= req;
      nonce <= req.start_nonce;
      attempts <= '0;
    end else if (cmd.next_nonce) begin
      nonce <= nonce_inc;
      attempts <= attempts + 64'd1;
    end
  end

  // Hash state, working variables, schedule window (w[0] is word t)
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (cmd.load_blk1) begin
      for (int i = 0; i < 8; i++) begin
        hv[i] <= slz_pkg::HInit[255-32*i -: 32];
        v[i]  <= slz_pkg::HInit[255-32*i -: 32];
      end
      w[0] <= job.target_w0[63:32]; w[1] <= job.target_w0[31:0];
      w[2] <= job.target_w1[63:32]; w[3] <= job.target_w1[31:0];
      w[4] <= job.target_w2[63:32]; w[5] <= job.target_w2[31:0];
      w[6] <= job.target_w3[63:32]; w[7] <= job.target_w3[31:0];
      w[8] <= slz_pkg::swap32(nonce_inc[31:0]);
      w[9] <= slz_pkg::swap32(nonce_inc[63:32]);
      w[10] <= job.filler_w0[63:32]; w[11] <= job.filler_w0[31:0];
      w[12] <= job.filler_w1[63:32]; w[13] <= job.filler_w1[31:0];
      w[14] <= job.filler_w2[63:32]; w[15] <= job.filler_w2[31:0];
      rnd <= '0;
    end else if (cmd.load_blk2) begin
      for (int i = 0; i < 8; i++) v[i] <= hv[i];
      for (int i = 1; i < 15; i++) w[i] <= '0;
      w[0] <= 32'h8000_0000;
      w[15] <= 32'd512;
      rnd <= '0;
    end else if (cmd.round) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
      rnd <= rnd + 6'd1;
      if (cmd.finish) begin
        hv[0] <= hv[0] + t1 + t2;
        hv[1] <= hv[1] + v[0];
        hv[2] <= hv[2] + v[1];
        hv[3] <= hv[3] + v[2];
        hv[4] <= hv[4] + v[3] + t1;
        hv[5] <= hv[5] + v[4];
        hv[6] <= hv[6] + v[5];
        hv[7] <= hv[7] + v[6];
      end
    end
  end

  // Leading zero test: the first need bits of the digest are all zero
  always_comb begin
    need = (difficulty > 9'(slz_pkg::HashBits)) ? 9'(slz_pkg::HashBits) : difficulty;
    nz_found = 1'b0;
    zeros = 9'(slz_pkg::HashBits);
    for (int i = 0; i < 256; i++) begin
      if (!nz_found && hv[i/32][31 - (i%32)]) begin
        nz_found = 1'b1;
        zeros = 9'(i);
      end
    end
  end

  assign limit = (max_attempts == '0) ? 64'd1 : max_attempts;
  assign sts.last_round = (rnd == 6'd63);
  assign sts.qualifies = (zeros >= need);
  assign sts.at_limit = (attempts >= limit);

  assign rsp.found = sts.qualifies;
  assign rsp.nonce_value = nonce;
  assign rsp.hashes_tried = attempts;

endmodule
